FILE: rtl/sitoa_pkg.sv
package sitoa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_BITS     = 6;
  localparam int CHAR_BITS      = 8;
  localparam int LEN_BITS       = 6;
  localparam int RADIX_MIN      = 2;
  localparam int RADIX_MAX      = 36;
  localparam int DEC_DIGITS     = 10;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;

  typedef struct packed {
    logic                  bad;
    logic                  neg;
    logic [RADIX_BITS-1:0] radix;
  } cls_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BAD,
    BK_DIV,
    BK_PUT,
    BK_SIGN,
    BK_READ,
    BK_EMIT
  } back_state_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
    if (d < RADIX_BITS'(DEC_DIGITS)) begin
      return CHAR_ZERO + CHAR_BITS'(d);
    end else begin
      return CHAR_A + CHAR_BITS'(d) - CHAR_BITS'(DEC_DIGITS);
    end
  endfunction

endpackage

FILE: rtl/sitoa_ram.sv
module sitoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sitoa_front.sv
module sitoa_front #(
  parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
  input  logic                              start,
  input  logic                              busy,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic [sitoa_pkg::RADIX_BITS-1:0]  radix,
  output logic                              push,
  output sitoa_pkg::cls_t                   cls,
  output logic [VALUE_BITS-1:0]             mag
);

  import sitoa_pkg::*;

  assign push = start & ~busy;

  always_comb begin
    cls.radix = radix;
    cls.bad   = (radix < RADIX_BITS'(RADIX_MIN)) || (radix > RADIX_BITS'(RADIX_MAX));
    cls.neg   = value[VALUE_BITS-1];
    // two's complement negate, most negative maps onto itself as unsigned
    mag       = cls.neg ? (~value + VALUE_BITS'(1)) : value;
  end

endmodule

FILE: rtl/sitoa_queue.sv
module sitoa_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = sitoa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  import sitoa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/sitoa_back.sv
module sitoa_back #(
  parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             empty,
  input  sitoa_pkg::cls_t                  cls,
  input  logic [VALUE_BITS-1:0]            mag,
  output logic                             pop,
  output logic                             strobe,
  output logic [sitoa_pkg::CHAR_BITS-1:0]  character,
  output logic [sitoa_pkg::LEN_BITS-1:0]   text_length,
  output logic                             bad_radix,
  output logic                             is_last
);

  import sitoa_pkg::*;

  localparam int AW = $clog2(VALUE_BITS);
  localparam int SW = $clog2(VALUE_BITS);
  localparam int NW = $clog2(VALUE_BITS + 1);

  back_state_t           state, state_next;
  logic [VALUE_BITS-1:0] quo, quo_next;
  logic [RADIX_BITS-1:0] rem, rem_next;
  logic [RADIX_BITS-1:0] radix_r, radix_r_next;
  logic                  neg_r, neg_r_next;
  logic [SW-1:0]         step, step_next;
  logic [NW-1:0]         ndig, ndig_next;
  logic [AW-1:0]         idx, idx_next;

  logic [RADIX_BITS:0]   rem_sh;
  logic [RADIX_BITS:0]   rem_sub;
  logic                  ge;
  logic [NW:0]           len_sum;
  logic                  we;
  logic [CHAR_BITS-1:0]  wdata;
  logic [CHAR_BITS-1:0]  rdata;

  sitoa_ram #(
    .WIDTH(CHAR_BITS),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (we),
    .waddr(ndig[AW-1:0]),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  // one restoring division step per cycle
  assign rem_sh  = {rem, quo[VALUE_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, radix_r};
  assign ge      = (rem_sh >= {1'b0, radix_r});
  assign wdata   = digit_char(rem);
  assign len_sum = {1'b0, ndig} + (NW + 1)'(neg_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    quo     <= quo_next;
    rem     <= rem_next;
    radix_r <= radix_r_next;
    neg_r   <= neg_r_next;
    step    <= step_next;
    ndig    <= ndig_next;
    idx     <= idx_next;
  end

  always_comb begin
    state_next   = state;
    quo_next     = quo;
    rem_next     = rem;
    radix_r_next = radix_r;
    neg_r_next   = neg_r;
    step_next    = step;
    ndig_next    = ndig;
    idx_next     = idx;
    pop          = 1'b0;
    we           = 1'b0;
    strobe       = 1'b0;
    character    = CHAR_NUL;
    text_length  = LEN_BITS'(len_sum);
    bad_radix    = 1'b0;
    is_last      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop          = 1'b1;
          radix_r_next = cls.radix;
          neg_r_next   = cls.neg;
          quo_next     = mag;
          rem_next     = '0;
          step_next    = '0;
          ndig_next    = '0;
          state_next   = cls.bad ? BK_BAD : BK_DIV;
        end
      end
      BK_BAD: begin
        strobe      = 1'b1;
        text_length = '0;
        bad_radix   = 1'b1;
        is_last     = 1'b1;
        state_next  = BK_IDLE;
      end
      BK_DIV: begin
        rem_next  = ge ? rem_sub[RADIX_BITS-1:0] : rem_sh[RADIX_BITS-1:0];
        quo_next  = {quo[VALUE_BITS-2:0], ge};
        step_next = step + SW'(1);
        if (step == SW'(VALUE_BITS - 1)) begin
          state_next = BK_PUT;
        end
      end
      BK_PUT: begin
        // rem holds the digit, quo the value left for the next digits
        we        = 1'b1;
        ndig_next = ndig + NW'(1);
        if (quo == '0) begin
          idx_next   = ndig[AW-1:0];
          state_next = neg_r ? BK_SIGN : BK_READ;
        end else begin
          rem_next   = '0;
          step_next  = '0;
          state_next = BK_DIV;
        end
      end
      BK_SIGN: begin
        strobe     = 1'b1;
        character  = CHAR_MINUS;
        state_next = BK_READ;
      end
      BK_READ: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        strobe    = 1'b1;
        character = rdata;
        is_last   = (idx == '0);
        if (idx == '0) begin
          state_next = BK_IDLE;
        end else begin
          idx_next   = idx - AW'(1);
          state_next = BK_READ;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/signed_integer_to_text_any_base.sv
// Converts a signed two's complement value to its text in radix 2 to 36, one ASCII
// character per word, most significant first, '-' ahead of negatives and lower-case
// letters for digits above 9. A radix outside 2 to 36 gives one word with bad_radix
// set and text_length 0. A command is taken when start is high and busy is low; a
// two-entry queue sits between the intake and the converter, so busy rises only when
// two commands are waiting. Each word is on the outputs for exactly one cycle, marked
// by strobe, and must be taken then: there is no way to hold words off. Each digit
// comes from the bit-serial divider (one quotient bit a cycle over all VALUE_BITS
// bits, then a step to store the digit); read-out from the digit buffer reads each
// digit and then sends it, after the sign word of a negative value. A command is
// picked up from the queue in the idle state before its conversion begins.
module signed_integer_to_text_any_base #(
  parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [VALUE_BITS-1:0]            value,
  input  logic [sitoa_pkg::RADIX_BITS-1:0] radix,
  output logic                             strobe,
  output logic [sitoa_pkg::CHAR_BITS-1:0]  character,
  output logic [sitoa_pkg::LEN_BITS-1:0]   text_length,
  output logic                             bad_radix,
  output logic                             is_last
);

  import sitoa_pkg::*;

  localparam int CLS_W = $bits(cls_t);
  localparam int QW    = CLS_W + VALUE_BITS;

  logic                  push;
  logic                  pop;
  logic                  empty;
  cls_t                  front_cls;
  cls_t                  back_cls;
  logic [VALUE_BITS-1:0] front_mag;
  logic [VALUE_BITS-1:0] back_mag;
  logic [QW-1:0]         pop_data;

  sitoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .start(start),
    .busy (busy),
    .value(value),
    .radix(radix),
    .push (push),
    .cls  (front_cls),
    .mag  (front_mag)
  );

  sitoa_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({front_cls, front_mag}),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (busy),
    .empty    (empty)
  );

  assign back_cls = cls_t'(pop_data[QW-1:VALUE_BITS]);
  assign back_mag = pop_data[VALUE_BITS-1:0];

  sitoa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .cls        (back_cls),
    .mag        (back_mag),
    .pop        (pop),
    .strobe     (strobe),
    .character  (character),
    .text_length(text_length),
    .bad_radix  (bad_radix),
    .is_last    (is_last)
  );

endmodule
